FILE: sv/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define NRTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define NRTE_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: sv/nrte_pkg.sv
`default_nettype none
package nrte_pkg;

  localparam int unsigned MAX_LINE_DEF = 256;

  localparam logic [61:0] BASE_MS_RST = 62'd1672531200000;
  localparam logic [26:0] DAY_MS      = 27'd86400000;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_RMC   = 2'd1;
  localparam logic [1:0] STAT_MISSING   = 2'd2;
  localparam logic [1:0] STAT_BAD_DIGIT = 2'd3;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_TIME,
    CAP_DATE
  } cap_kind_t;

  typedef enum logic [1:0] {
    CS_RUN,
    CS_CALC,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic calc_en;
    logic launch;
    logic load_out;
  } nrte_cmd_t;

  typedef struct packed {
    logic       line_end;
    logic [1:0] status;
  } nrte_stat_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24; // $
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4d; // M
      3'd5:    c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // cumulative days before month 1..13, no leap days; any other value adds nothing
  function automatic logic [8:0] days_before(input logic [7:0] mon);
    logic [8:0] d;
    case (mon)
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      8'd13:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: sv/nmea_rmc_time_extractor.sv
// A byte that does not end a line is taken one byte per cycle while in_stall is low.
// A line-ending byte starts the arithmetic sequence in CS_CALC; its beat is then loaded
// into the output register from CS_DONE, and in_stall stays high until that load.
// The output register frees the input side while a result beat waits on out_stall.
// Reset (rst_n, synchronous, active low) clears line state, empties the output and
// loads base_ms with 1672531200000; digit stores are not reset.
`default_nettype none
module nmea_rmc_time_extractor #(
  parameter int unsigned MAX_LINE = nrte_pkg::MAX_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [62:0]      out_time_ms,
  // base_ms register
  input  wire logic        cfg_we,
  input  wire logic [61:0] cfg_wdata
);
  import nrte_pkg::*;

  nrte_cmd_t       cmd;
  nrte_stat_t      st;
  logic            byte_en;
  logic [7:0][3:0] time_dig;
  logic [5:0][3:0] date_dig;

  // Sequencer: byte acceptance, calc step count, output beat handshake.
  nrte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_en   (byte_en),
    .st        (st),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Line parser: prefix check, comma count, capture windows for
  // hhmmss.ss (field 1) and ddmmyy (field 9), status at line end.
  nrte_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .rx_byte  (in_rx_byte),
    .st       (st),
    .time_dig (time_dig),
    .date_dig (date_dig)
  );

  // Timestamp datapath: digit pairs, day count and time of day through a
  // short chain of registered constant multiplies, then base + days + tod.
  // The parser holds the digits steady while the input is stalled.
  nrte_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .time_dig  (time_dig),
    .date_dig  (date_dig),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (out_status),
    .time_ms   (out_time_ms)
  );

endmodule
`default_nettype wire

FILE: sv/nrte_parse.sv
`default_nettype none
module nrte_parse #(
  parameter int unsigned MAX_LINE = nrte_pkg::MAX_LINE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [7:0]        rx_byte,
  output nrte_pkg::nrte_stat_t   st,
  output logic [7:0][3:0]        time_dig,
  output logic [5:0][3:0]        date_dig
);
  import nrte_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LINE);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [2:0]       pm_r, pm_nxt;
  logic             pf_r, pf_nxt;
  logic [3:0]       fc_r, fc_nxt;
  logic [3:0]       off_r, off_nxt;
  cap_kind_t        cap_r, cap_nxt;
  logic             tseen_r, tseen_nxt;
  logic             dseen_r, dseen_nxt;
  logic             err_r, err_nxt;
  logic [7:0][3:0]  tdig_r;
  logic [5:0][3:0]  ddig_r;

  logic       tw_en, dw_en, is_dig;
  logic [2:0] t_idx, d_idx;
  logic [3:0] dig_val;
  logic [7:0] sub;

  assign sub     = rx_byte - CH_ZERO;
  assign dig_val = sub[3:0];
  assign is_dig  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  always_comb begin
    len_nxt   = len_r;
    pm_nxt    = pm_r;
    pf_nxt    = pf_r;
    fc_nxt    = fc_r;
    off_nxt   = off_r;
    cap_nxt   = cap_r;
    tseen_nxt = tseen_r;
    dseen_nxt = dseen_r;
    err_nxt   = err_r;
    tw_en     = 1'b0;
    dw_en     = 1'b0;
    t_idx     = off_r[2:0];
    d_idx     = off_r[2:0];
    st        = '{line_end: 1'b0, status: STAT_OK};
    if (byte_en) begin
      if (len_r < LEN_W'(6)) begin
        if (!pf_r && rx_byte == prefix_char(len_r[2:0])) begin
          pm_nxt = pm_r + 3'd1;
        end else begin
          pf_nxt = 1'b1;
        end
      end

      if (cap_r != CAP_NONE) begin
        if (off_r == 4'd0 && rx_byte == CH_COMMA) begin
          cap_nxt = CAP_NONE; // empty field
        end else if (cap_r == CAP_TIME) begin
          if (off_r < 4'd6) begin
            tw_en = 1'b1;
          end else if (off_r == 4'd7 || off_r == 4'd8) begin
            tw_en = 1'b1;
            t_idx = 3'(off_r - 4'd1);
          end
          if (tw_en && !is_dig) begin
            err_nxt = 1'b1;
          end
          if (off_r == 4'd8) begin
            tseen_nxt = 1'b1;
            cap_nxt   = CAP_NONE;
            off_nxt   = 4'd0;
          end else begin
            off_nxt = off_r + 4'd1;
          end
        end else begin
          dw_en = 1'b1;
          if (!is_dig) begin
            err_nxt = 1'b1;
          end
          if (off_r == 4'd5) begin
            dseen_nxt = 1'b1;
            cap_nxt   = CAP_NONE;
            off_nxt   = 4'd0;
          end else begin
            off_nxt = off_r + 4'd1;
          end
        end
      end

      if (rx_byte == CH_COMMA) begin
        fc_nxt = (fc_r == 4'd15) ? fc_r : fc_r + 4'd1;
        if (fc_r != 4'd15 && fc_nxt == 4'd1) begin
          cap_nxt = CAP_TIME;
          off_nxt = 4'd0;
        end else if (fc_r != 4'd15 && fc_nxt == 4'd9) begin
          cap_nxt = CAP_DATE;
          off_nxt = 4'd0;
        end
      end

      len_nxt = len_r + LEN_W'(1);
      st.line_end = (rx_byte == CH_NL) || (len_r == LEN_W'(MAX_LINE - 1));

      if (pf_nxt || pm_nxt != 3'd6) begin
        st.status = STAT_NOT_RMC;
      end else if (!tseen_nxt || !dseen_nxt) begin
        st.status = STAT_MISSING;
      end else if (err_nxt) begin
        st.status = STAT_BAD_DIGIT;
      end else begin
        st.status = STAT_OK;
      end

      if (st.line_end) begin
        len_nxt   = '0;
        pm_nxt    = 3'd0;
        pf_nxt    = 1'b0;
        fc_nxt    = 4'd0;
        off_nxt   = 4'd0;
        cap_nxt   = CAP_NONE;
        tseen_nxt = 1'b0;
        dseen_nxt = 1'b0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      pm_r    <= 3'd0;
      pf_r    <= 1'b0;
      fc_r    <= 4'd0;
      off_r   <= 4'd0;
      cap_r   <= CAP_NONE;
      tseen_r <= 1'b0;
      dseen_r <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      pm_r    <= pm_nxt;
      pf_r    <= pf_nxt;
      fc_r    <= fc_nxt;
      off_r   <= off_nxt;
      cap_r   <= cap_nxt;
      tseen_r <= tseen_nxt;
      dseen_r <= dseen_nxt;
      err_r   <= err_nxt;
    end
  end

  // digit stores: no reset; the result uses them only after both windows completed
  always_ff @(posedge clk) begin
    if (tw_en) begin
      tdig_r[t_idx] <= dig_val;
    end
    if (dw_en) begin
      ddig_r[d_idx] <= dig_val;
    end
  end

  assign time_dig = tdig_r;
  assign date_dig = ddig_r;

  `include "assert_macros.svh"

  `NRTE_NEVER(a_prefix_bound, pm_r > 3'd6, "prefix match count out of range")
  `NRTE_ASSERT(a_idle_offset, (cap_r == CAP_NONE) |-> (off_r == 4'd0), "offset without capture")

endmodule
`default_nettype wire

FILE: sv/nrte_calc.sv
`default_nettype none
module nrte_calc (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nrte_pkg::nrte_cmd_t  cmd,
  input  wire nrte_pkg::nrte_stat_t st,
  input  wire logic [7:0][3:0]      time_dig,
  input  wire logic [5:0][3:0]      date_dig,
  input  wire logic                 cfg_we,
  input  wire logic [61:0]          cfg_wdata,
  output logic [1:0]                status,
  output logic [62:0]               time_ms
);
  import nrte_pkg::*;

  function automatic logic [7:0] pair(input logic [3:0] hi, input logic [3:0] lo);
    return (8'(hi) << 3) + (8'(hi) << 1) + 8'(lo);
  endfunction

  logic [61:0] base_r;
  logic [1:0]  stat_r;

  // step 0: two-digit values
  logic [7:0]  day_r, mon_r, hh_r, mm_r, ss_r, cc_r;
  // step 1
  logic [10:0] days_r;   // two's complement, -1 for day zero of January
  logic [13:0] hm_r;
  // step 2
  logic [62:0] dms_r;
  logic [19:0] hms_r;
  // step 3
  logic [29:0] tod_r;
  logic [62:0] sum_r;

  logic [1:0]  out_stat_r;
  logic [62:0] out_ms_r;

  logic signed [38:0] dms_prod;
  logic [62:0]        ms_nxt;

  assign dms_prod = $signed(days_r) * $signed({1'b0, DAY_MS});
  assign ms_nxt   = (stat_r == STAT_OK) ? sum_r + 63'(tod_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_MS_RST;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      stat_r <= st.status;
    end
    if (cmd.calc_en) begin
      day_r  <= pair(date_dig[0], date_dig[1]);
      mon_r  <= pair(date_dig[2], date_dig[3]);
      hh_r   <= pair(time_dig[0], time_dig[1]);
      mm_r   <= pair(time_dig[2], time_dig[3]);
      ss_r   <= pair(time_dig[4], time_dig[5]);
      cc_r   <= pair(time_dig[6], time_dig[7]);
      days_r <= 11'(days_before(mon_r)) + 11'(day_r) - 11'd1;
      hm_r   <= 14'(hh_r) * 14'd60 + 14'(mm_r);
      dms_r  <= {{24{dms_prod[38]}}, dms_prod};
      hms_r  <= 20'(hm_r) * 20'd60 + 20'(ss_r);
      tod_r  <= 30'(hms_r) * 30'd1000 + 30'(cc_r) * 30'd10;
      sum_r  <= 63'(base_r) + dms_r;
    end
    if (cmd.load_out) begin
      out_stat_r <= stat_r;
      out_ms_r   <= ms_nxt;
    end
  end

  assign status  = out_stat_r;
  assign time_ms = out_ms_r;

endmodule
`default_nettype wire

FILE: sv/nrte_ctrl.sv
`default_nettype none
module nrte_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      byte_en,
  input  wire nrte_pkg::nrte_stat_t st,
  output nrte_pkg::nrte_cmd_t       cmd,
  output logic                      out_valid,
  input  wire logic                 out_stall
);
  import nrte_pkg::*;

  localparam int unsigned CALC_STEPS = 4;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = (state_r != CS_RUN);
    byte_en   = in_valid && (state_r == CS_RUN);
    case (state_r)
      CS_RUN: begin
        if (st.line_end) begin
          cmd.launch = 1'b1;
          state_nxt  = CS_CALC;
          step_nxt   = 2'd0;
        end
      end
      CS_CALC: begin
        cmd.calc_en = 1'b1;
        if (step_r == 2'(CALC_STEPS - 1)) begin
          state_nxt = CS_DONE;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      CS_DONE: begin
        if (!ov_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = CS_RUN;
        end
      end
      default: begin
        state_nxt = CS_RUN;
      end
    endcase
    if (cmd.load_out) begin
      ov_nxt = 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RUN;
      step_r  <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  `include "assert_macros.svh"

  `NRTE_ASSERT(a_launch_calc, st.line_end |=> (state_r == CS_CALC && step_r == 2'd0), "line end did not start calc")
  `NRTE_NEVER(a_no_overwrite, cmd.load_out && ov_r && out_stall, "pending result overwritten")

endmodule
`default_nettype wire

FILE: verif/nmea_rmc_time_extractor_tb.sv
module nmea_rmc_time_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nrte_pkg::*;

  localparam int unsigned LINE_MAX      = nrte_pkg::MAX_LINE_DEF;
  localparam logic [61:0] EPOCH_2023_MS = 62'd1672531200000;
  localparam logic [61:0] BASE_TOP      = {62{1'b1}};
  localparam logic [63:0] MS_PER_DAY    = 64'd86_400_000;
  localparam logic [47:0] RMC_TAG       = "$GPRMC";
  localparam logic [7:0]  CH_DOT        = 8'h2e;
  localparam logic [7:0]  CH_VT         = 8'h0b;

  // line end -> result goes through the calc and done states; leave a little slack on top
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_BYTES  = 120;
  localparam int unsigned RANDOM_FIXES  = 2;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] time_ms;
  } fix_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  out_status;
  logic [62:0] out_time_ms;
  logic        cfg_we     = 1'b0;
  logic [61:0] cfg_wdata  = '0;

  nmea_rmc_time_extractor #(
    .MAX_LINE(LINE_MAX)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_time_ms(out_time_ms),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  fix_t        pending_fixes[$];   // results owed by the DUT, oldest first
  logic [7:0]  line_buf[$];        // line being composed before it is sent
  int unsigned sent_cnt    = 0;    // bytes accepted
  int unsigned fix_cnt     = 0;    // results predicted
  int unsigned got_cnt     = 0;    // results matched
  int unsigned fail_cnt    = 0;
  int unsigned cfg_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stat_hits[4];
  bit          src_idle_on = 1'b1; // sender may insert gaps
  bit          snk_idle_on = 1'b1; // receiver may stall
  bit          hold_req    = 1'b0; // ask receiver for one long stall
  bit          hold_busy   = 1'b0;
  fix_t        want;

  // ---------------------------------------------------------------------------
  // Line parser mirror: same per-byte bookkeeping as the block
  // ---------------------------------------------------------------------------
  logic [61:0] base_reg;
  int unsigned ln_len;
  int unsigned pfx_hits;
  bit          pfx_bad;
  int unsigned comma_cnt;
  int unsigned win_pos;
  cap_kind_t   win_kind;
  logic [3:0]  hms_dig[8];  // h h m m s s c c
  logic [3:0]  dmy_dig[6];  // d d m m y y
  bit          hms_done;
  bit          dmy_done;
  bit          bad_digit;

  function automatic void clear_line_state();
    ln_len    = 0;
    pfx_hits  = 0;
    pfx_bad   = 1'b0;
    comma_cnt = 0;
    win_pos   = 0;
    win_kind  = CAP_NONE;
    hms_done  = 1'b0;
    dmy_done  = 1'b0;
    bad_digit = 1'b0;
  endfunction

  // digit positions keep the low nibble of (byte - '0'); anything else flags
  function automatic logic [3:0] take_digit(input logic [7:0] b);
    if (b < CH_ZERO || b > CH_NINE) bad_digit = 1'b1;
    return 4'(b - CH_ZERO);
  endfunction

  // days before the given month, Jan..Dec plus a 13th month, no leap years
  function automatic int unsigned days_ahead(input int unsigned mon);
    int unsigned acc;
    acc = 0;
    if (mon <= 13) begin
      for (int unsigned m = 1; m < mon; m++) begin
        if (m == 2) acc += 28;
        else if (m == 4 || m == 6 || m == 9 || m == 11) acc += 30;
        else acc += 31;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
    return 64'(hi) * 64'd10 + 64'(lo);
  endfunction

  // day zero gives minus one day; everything wraps at 63 bits
  function automatic logic [62:0] fix_time_ms();
    logic [63:0] days;
    logic [63:0] tod;
    logic [63:0] total;
    days  = 64'(days_ahead(int'(bcd_pair(dmy_dig[2], dmy_dig[3]))))
            + bcd_pair(dmy_dig[0], dmy_dig[1]) - 64'd1;
    tod   = ((bcd_pair(hms_dig[0], hms_dig[1]) * 64'd60 + bcd_pair(hms_dig[2], hms_dig[3]))
             * 64'd60 + bcd_pair(hms_dig[4], hms_dig[5])) * 64'd1000
            + bcd_pair(hms_dig[6], hms_dig[7]) * 64'd10;
    total = {2'b00, base_reg} + days * MS_PER_DAY + tod;
    return total[62:0];
  endfunction

  // Advance the mirror by one accepted byte; queue a result at line end.
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned pos;
    fix_t        fix;
    pos = ln_len;
    if (pos < 6) begin
      if (!pfx_bad && b == RMC_TAG[47 - 8 * pos -: 8]) pfx_hits++;
      else pfx_bad = 1'b1;
    end
    if (win_kind != CAP_NONE) begin
      if (win_pos == 0 && b == CH_COMMA) begin
        win_kind = CAP_NONE;          // empty field
      end else if (win_kind == CAP_TIME) begin
        // offset 6 is the '.' and is not looked at
        if (win_pos < 6) hms_dig[win_pos] = take_digit(b);
        else if (win_pos >= 7) hms_dig[win_pos - 1] = take_digit(b);
        win_pos++;
        if (win_pos >= 9) begin
          hms_done = 1'b1;
          win_kind = CAP_NONE;
          win_pos  = 0;
        end
      end else begin
        dmy_dig[win_pos] = take_digit(b);
        win_pos++;
        if (win_pos >= 6) begin
          dmy_done = 1'b1;
          win_kind = CAP_NONE;
          win_pos  = 0;
        end
      end
    end
    // commas inside a window still count toward the field number
    if (b == CH_COMMA) begin
      if (comma_cnt < 15) comma_cnt++;
      if (comma_cnt == 1) begin
        win_kind = CAP_TIME;
        win_pos  = 0;
      end else if (comma_cnt == 9) begin
        win_kind = CAP_DATE;
        win_pos  = 0;
      end
    end
    ln_len++;
    if (b == CH_NL || ln_len >= LINE_MAX) begin
      fix.time_ms = '0;
      if (pfx_bad || pfx_hits != 6) begin
        fix.status = STAT_NOT_RMC;
      end else if (!hms_done || !dmy_done) begin
        fix.status = STAT_MISSING;
      end else if (bad_digit) begin
        fix.status = STAT_BAD_DIGIT;
      end else begin
        fix.status  = STAT_OK;
        fix.time_ms = fix_time_ms();
      end
      pending_fixes.push_back(fix);
      fix_cnt++;
      clear_line_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: one compare per accepted result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_fixes.size() == 0) begin
        fail_cnt++;
        $display("%0t ns: result beat, expected none, actual status %0d time_ms %0d",
                 $time, out_status, out_time_ms);
      end else begin
        want = pending_fixes.pop_front();
        if (out_status !== want.status || out_time_ms !== want.time_ms) begin
          fail_cnt++;
          if (out_status !== want.status)
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          if (out_time_ms !== want.time_ms)
            $display("%0t ns: time_ms mismatch, expected %0d, actual %0d",
                     $time, want.time_ms, out_time_ms);
        end else begin
          got_cnt++;
          stat_hits[want.status]++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results still owed",
               $time, cycle_cnt, pending_fixes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stall bursts, calm stretches, and one long hold
  // on request so the block backs up into the byte channel.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacer
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_busy = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req  = 1'b0;
        hold_busy = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte channel and config helpers
  // ---------------------------------------------------------------------------

  // One beat on the byte channel. Valid stays up after acceptance so the
  // next call can follow back to back; a gap drops it first.
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_byte(b);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  // Sender stops and waits until every owed result is out and the
  // arithmetic pipe has had time to go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only call right after wait_idle
  task automatic write_base(input logic [61:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_reg = v;
    cfg_cnt++;
  endtask

  function automatic logic [61:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return BASE_TOP;
      2:       return EPOCH_2023_MS;
      default: return 62'({$urandom, $urandom});
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Line composers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_COMMA) c = 8'h2a;
    return c;
  endfunction

  // any byte except newline, so a padded line ends on length alone
  function automatic logic [7:0] pad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_NL) c = CH_VT;
    return c;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_pair(input int unsigned v);
    line_buf.push_back(CH_ZERO + 8'(v / 10));
    line_buf.push_back(CH_ZERO + 8'(v % 10));
  endfunction

  function automatic void add_filler(input int unsigned n);
    repeat (n) line_buf.push_back(field_char());
  endfunction

  function automatic void pad_to(input int unsigned target);
    while (line_buf.size() < target) line_buf.push_back(pad_char());
  endfunction

  // mostly plausible, now and then any two digits
  function automatic int unsigned pick2(input int unsigned lim);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, lim);
  endfunction

  // Well-formed RMC body without the line end; time or date sometimes empty.
  function automatic void compose_rmc();
    add_text("$GPRMC,");
    if ($urandom_range(0, 15) != 0) begin
      add_pair(pick2(23));
      add_pair(pick2(59));
      add_pair(pick2(59));
      line_buf.push_back(($urandom_range(0, 7) == 0) ? field_char() : CH_DOT);
      add_pair($urandom_range(0, 99));
    end
    for (int k = 2; k <= 9; k++) begin
      line_buf.push_back(CH_COMMA);
      if (k < 9) add_filler($urandom_range(0, 5));
    end
    if ($urandom_range(0, 15) != 0) begin
      add_pair(pick2(31));
      add_pair(pick2(14));
      add_pair($urandom_range(0, 99));
    end
    if ($urandom_range(0, 1) != 0) begin
      line_buf.push_back(CH_COMMA);
      add_filler($urandom_range(0, 8));
    end
  endfunction

  // One random line: mostly good sentences, some damaged, truncated,
  // overlong or plain noise. Every line is closed before returning.
  function automatic void random_line();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  c;
    kind = $urandom_range(0, 99);
    if (kind < 68) begin
      compose_rmc();
      if ($urandom_range(0, 5) == 0)
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      line_buf.push_back(CH_NL);
    end else if (kind < 80) begin
      compose_rmc();
      n = $urandom_range(1, line_buf.size());
      while (line_buf.size() > n) void'(line_buf.pop_back());
      line_buf.push_back(CH_NL);
    end else if (kind < 95) begin
      // noise heavy in commas and digits; may hold newlines of its own
      if ($urandom_range(0, 1) != 0) add_text("$GPRMC");
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(0, 2))
          0:       c = CH_COMMA;
          1:       c = CH_ZERO + 8'($urandom_range(0, 9));
          default: c = 8'($urandom_range(0, 255));
        endcase
        line_buf.push_back(c);
      end
      line_buf.push_back(CH_NL);
    end else begin
      // overlong: ends on the byte limit, or on a newline that is byte LINE_MAX
      compose_rmc();
      if ($urandom_range(0, 1) != 0) begin
        pad_to(LINE_MAX);
      end else begin
        pad_to(LINE_MAX - 1);
        line_buf.push_back(CH_NL);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // good fixes, digit extremes, month table ends, day zero wrap
  task automatic test_valid_fixes();
    send_text("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
    send_text("$GPRMC,000000.00,,,,,,,,010100\n");
    send_text("$GPRMC,999999.99,,,,,,,,999999\n");
    send_text("$GPRMC,235959.99,A,,,,,,,311223\n");
    send_text("$GPRMC,120000.00,,,,,,,,011300\n");
    send_text("$GPRMC,120000.00,,,,,,,,151400\n");
    send_text("$GPRMC,000000.00,,,,,,,,000000\n");
    send_text("$GPRMC,123519x00,,,,,,,,230394\n");
    wait_idle();
  endtask

  // empty fields and lines that stop inside a window
  task automatic test_missing_fields();
    send_text("$GPRMC,,A,4807.038,N,01131.000,E,022.4,084.4,230394,,\n");
    send_text("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,,003.1\n");
    send_text("$GPRMC,1235\n");
    send_text("$GPRMC,123519.00,,,,,,,,2303\n");
    send_text("$GPRMC,,,,,,,,,,,,,,,,,,,,\n");
    wait_idle();
  endtask

  // non-digits in windows, commas swallowed by the time window
  task automatic test_digit_checks();
    send_text("$GPRMC,12a519.00,,,,,,,,230394\n");
    send_text("$GPRMC,123519.00,,,,,,,,23O394\n");
    send_text("$GPRMC,12,A,48,N,0,E,0,0,230394\n");
    send_text("$GPRMC,123519.00,,,,,,,,230394,12a\n");
    send_text("$GPRMC,12a519.00,,,,,,,,2303\n");
    wait_idle();
  endtask

  // prefix failures, outranking the other statuses; raw byte extremes
  task automatic test_foreign_lines();
    send_text("\n");
    send_text("$GPGGA,123519.00,,,,,,,,230394\n");
    send_text("$GPRM\n");
    send_text("$gprmc,12a519.00,,,,,,,,230394\n");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_NL);
    wait_idle();
  endtask

  // lines cut by the byte limit instead of a newline
  task automatic test_line_limit();
    add_text("$GPRMC,235959.99,,,,,,,,281299,");
    pad_to(LINE_MAX);
    flush_line();
    add_text("$GPRMC,010203.04,,,,,,,,050607,");
    pad_to(LINE_MAX - 1);
    line_buf.push_back(CH_NL);
    flush_line();
    wait_idle();
  endtask

  // base_ms at zero, at its top value, random, then back to the default
  task automatic test_base_register();
    write_base('0);
    send_text("$GPRMC,000000.00,,,,,,,,000000\n");
    wait_idle();
    write_base(BASE_TOP);
    send_text("$GPRMC,999999.99,,,,,,,,991399\n");
    wait_idle();
    write_base(62'({$urandom, $urandom}));
    compose_rmc();
    line_buf.push_back(CH_NL);
    flush_line();
    wait_idle();
    write_base(EPOCH_2023_MS);
  endtask

  // Receiver holds off for a long stretch while short lines keep coming:
  // the output register fills and the byte channel has to stall.
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    while (!hold_busy) @(posedge clk);
    repeat (4) begin
      send_text("\n");
      send_text("$GPRMC,010203.04,,,,,,,,050607\n");
    end
    wait_idle();
    src_idle_on = 1'b1;
  endtask

  // bulk random lines; base_ms rewritten every few hundred bytes
  task automatic test_random_traffic();
    int unsigned first_byte;
    int unsigned first_fix;
    int unsigned since_cfg;
    first_byte  = sent_cnt;
    first_fix   = fix_cnt;
    since_cfg   = 0;
    snk_idle_on = 1'b1;
    while (sent_cnt - first_byte < RANDOM_BYTES || fix_cnt - first_fix < RANDOM_FIXES) begin
      src_idle_on = ($urandom_range(0, 4) != 0);
      random_line();
      since_cfg += line_buf.size();
      flush_line();
      if (since_cfg >= 300) begin
        wait_idle();
        write_base(pick_base());
        since_cfg = 0;
      end
    end
    wait_idle();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_unthrottled_tail();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (3) begin
      compose_rmc();
      line_buf.push_back(CH_NL);
      flush_line();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned guard;
    base_reg = EPOCH_2023_MS;
    for (int i = 0; i < 8; i++) hms_dig[i] = '0;
    for (int i = 0; i < 6; i++) dmy_dig[i] = '0;
    for (int i = 0; i < 4; i++) stat_hits[i] = 0;
    clear_line_state();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_fixes();
    test_missing_fields();
    test_digit_checks();
    test_foreign_lines();
    test_line_limit();
    test_base_register();
    test_output_backpressure();
    test_random_traffic();
    test_unthrottled_tail();

    // bounded drain, then anything still owed is a failure
    guard = 0;
    while (pending_fixes.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_fixes.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_fixes.size());
      fail_cnt += pending_fixes.size();
    end

    $display("Run covered %0d bytes and %0d line results: ok %0d, not RMC %0d, missing %0d,",
             sent_cnt, got_cnt, stat_hits[0], stat_hits[1], stat_hits[2]);
    $display("  bad digit %0d; %0d base_ms writes incl. zero and top; long output hold-off done",
             stat_hits[3], cfg_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
